[rtl/wic_pkg.sv]
// ----------------------------------------------------------------------------
// wic_pkg: shared types and constants of the interval cover engine
// Widths of points, tree nodes and costs, interface sizes, and the
// command and status words between the controller and the datapath.
// ----------------------------------------------------------------------------
package wic_pkg;

	// Point and tree geometry.
	localparam int PT_W      = 19;
	localparam int LEAVES    = 1 << PT_W;
	localparam int NODE_W    = PT_W + 1;
	localparam int NODES     = 1 << NODE_W;
	localparam int IDX_W     = NODE_W + 1;
	localparam int INIT_NODE = LEAVES + 1;

	// Cost arithmetic.
	localparam int COST_W    = 48;
	localparam int IN_COST_W = 32;
	localparam logic [COST_W-1:0] UNREACH = {COST_W{1'b1}};

	// Stream word sizes.
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 96;
	localparam int M_TUSER_W = 2;

	// Register port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_TARGET = 1'b0;
	localparam logic [PT_W-1:0] TARGET_RST = 19'd298298;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic query;
		logic sum;
		logic update;
		logic tread;
		logic tcap;
	} wic_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic query_done;
		logic update_done;
	} wic_sts_t;

	function automatic logic [COST_W-1:0] cost_min(input logic [COST_W-1:0] a,
			input logic [COST_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

[rtl/weighted_interval_cover_dp_core.sv]
// Flow: an accepted word passes through the range query (20 tree levels), the
// sum, the path update, the target read and capture, and the load of its
// result word into the output register once that register is free. One word
// is in work at a time; the next word can be taken in the cycle after a result
// loads.
// Reset: asynchronous; clears all 1048576 tree nodes first, s_tready low.
// ----------------------------------------------------------------------------
// weighted_interval_cover_dp_core: minimum cost interval cover engine
// Takes intervals sorted by end point, keeps the cover cost table in a min
// segment tree and returns the interval's reach cost and the current cost
// of covering through the configured target point.
// ----------------------------------------------------------------------------
module weighted_interval_cover_dp_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// APB register port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [wic_pkg::PADDR_W-1:0]      paddr,
	input  logic [wic_pkg::PDATA_W-1:0]      pwdata,
	output logic [wic_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready,
	// Input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata: start_point[18:0], end_point[37:19], interval_cost[69:38], zero
	input  logic [wic_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic                             s_tlast,
	// Output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata: reach_cost[47:0], answer_cost[95:48]
	output logic [wic_pkg::M_TDATA_W-1:0]    m_tdata,
	// m_tuser: reach_valid[0], answer_found[1]
	output logic [wic_pkg::M_TUSER_W-1:0]    m_tuser,
	output logic                             m_tlast
);
	import wic_pkg::*;

	wic_cmd_t          cmd;
	wic_sts_t          sts;
	logic              out_free;
	logic              out_load;
	logic [PT_W-1:0]   target_q;
	logic              cfg_wr;
	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;
	logic              m_tlast_q;
	logic [COST_W-1:0] reach_cost;
	logic              reach_valid;
	logic [COST_W-1:0] answer_cost;
	logic              answer_found;
	logic              answer_final;

	// Register port: writes complete in the access cycle, no wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_TARGET) ? PDATA_W'(target_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
		end else if (cfg_wr && (paddr[2] == REG_TARGET)) begin
			target_q <= pwdata[PT_W-1:0];
		end
	end

	// Controller and datapath.
	wic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.s_tready (s_tready),
		.out_load (out_load)
	);

	wic_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.start_point   (s_tdata[PT_W-1:0]),
		.end_point     (s_tdata[2*PT_W-1:PT_W]),
		.interval_cost (s_tdata[2*PT_W+IN_COST_W-1:2*PT_W]),
		.last_interval (s_tlast),
		.target_point  (target_q),
		.reach_cost    (reach_cost),
		.reach_valid   (reach_valid),
		.answer_cost   (answer_cost),
		.answer_found  (answer_found),
		.answer_final  (answer_final)
	);

	// Output register: holds a finished word until it is taken.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {answer_cost, reach_cost};
			m_tuser_q <= {answer_found, reach_valid};
			m_tlast_q <= answer_final;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef NO_ASSERTIONS
	// A result is never loaded over a word that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over a pending output word");

	// An unreachable prefix always reports the saturated cost.
	a_reach_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[COST_W-1:0] == UNREACH))
		else $error("unreachable prefix without saturated reach cost");

	// An uncovered target reports a zero answer cost.
	a_answer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata[2*COST_W-1:COST_W] == '0))
		else $error("uncovered target with nonzero answer cost");

	// No word is taken while the tree clearing pass runs.
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !s_tready)
		else $error("input accepted during the clearing pass");
`endif

endmodule

[rtl/wic_ctrl.sv]
// ----------------------------------------------------------------------------
// wic_ctrl: sequencer of the interval cover engine
// Steps one word through the clearing pass, range query, sum, path
// update, target read and output hand-off.
// ----------------------------------------------------------------------------
module wic_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              out_free,
	input  wic_pkg::wic_sts_t sts,
	output wic_pkg::wic_cmd_t cmd,
	output logic              s_tready,
	output logic              out_load
);
	import wic_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_QRY   = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_UPD   = 3'd4;
	localparam logic [2:0] ST_TGT   = 3'd5;
	localparam logic [2:0] ST_TRES  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// Next state and command decode.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_QRY;
				end
			end
			ST_QRY: begin
				cmd.query = 1'b1;
				if (sts.query_done) begin
					state_nxt = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum   = 1'b1;
				state_nxt = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				if (sts.update_done) begin
					state_nxt = ST_TGT;
				end
			end
			ST_TGT: begin
				cmd.tread = 1'b1;
				state_nxt = ST_TRES;
			end
			ST_TRES: begin
				cmd.tcap  = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					out_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[rtl/wic_dp.sv]
// ----------------------------------------------------------------------------
// wic_dp: datapath of the interval cover engine
// Holds the min segment tree in a two-read, one-write memory, walks the
// range query and the leaf-to-root update one level per cycle, and keeps
// the result fields.
// ----------------------------------------------------------------------------
module wic_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wic_pkg::wic_cmd_t               cmd,
	output wic_pkg::wic_sts_t               sts,
	input  logic [wic_pkg::PT_W-1:0]        start_point,
	input  logic [wic_pkg::PT_W-1:0]        end_point,
	input  logic [wic_pkg::IN_COST_W-1:0]   interval_cost,
	input  logic                            last_interval,
	input  logic [wic_pkg::PT_W-1:0]        target_point,
	output logic [wic_pkg::COST_W-1:0]      reach_cost,
	output logic                            reach_valid,
	output logic [wic_pkg::COST_W-1:0]      answer_cost,
	output logic                            answer_found,
	output logic                            answer_final
);
	import wic_pkg::*;

	// Tree storage, node 1 is the root, leaves start at LEAVES.
	logic [COST_W-1:0] tree_mem [NODES];

	logic [COST_W-1:0]    rd0_q, rd1_q;
	logic                 rd_en0, rd_en1;
	logic [NODE_W-1:0]    rd_addr0, rd_addr1;
	logic                 wr_en;
	logic [NODE_W-1:0]    wr_addr;
	logic [COST_W-1:0]    wr_data;

	logic [NODE_W-1:0]    clr_q;
	logic [IDX_W-1:0]     lo_q, hi_q;
	logic [IDX_W-1:0]     hi_m1;
	logic                 qv0_q, qv1_q;
	logic [COST_W-1:0]    best_q;
	logic [IN_COST_W-1:0] cost_q;
	logic                 last_q;
	logic [NODE_W-1:0]    u_q;
	logic                 wpend_q;
	logic [NODE_W-1:0]    waddr_q;
	logic                 tok_q;
	logic [COST_W-1:0]    reach_cost_q;
	logic                 reach_valid_q;
	logic [COST_W-1:0]    answer_cost_q;
	logic                 answer_found_q;

	logic [PT_W:0]        e1;
	logic [PT_W-1:0]      hc;
	logic                 q_empty;
	logic [IDX_W-1:0]     lo_init, hi_init;
	logic                 q_issue, u_issue;
	logic [COST_W-1:0]    fold0, fold1;
	logic                 best_ok;
	logic [COST_W:0]      sum_full;
	logic [COST_W-1:0]    sum_sat;
	logic [PT_W:0]        t1;
	logic                 t_ok;
	logic [COST_W-1:0]    ans;
	logic                 clr_path;
	logic [COST_W-1:0]    clr_val;

	// Query bounds from the incoming word: entries start .. end+1, clipped
	// to the table, as half-open node indices at leaf level.
	always_comb begin
		e1      = {1'b0, end_point} + (PT_W+1)'(1);
		hc      = e1[PT_W] ? PT_W'(LEAVES - 1) : e1[PT_W-1:0];
		q_empty = start_point > hc;
		lo_init = IDX_W'(LEAVES) + IDX_W'(start_point);
		hi_init = q_empty ? lo_init : (IDX_W'(LEAVES) + IDX_W'(hc) + IDX_W'(1));
	end

	// Per-level query issue and fold of the data read in the previous cycle.
	assign q_issue = cmd.query && (lo_q < hi_q);
	assign hi_m1   = hi_q - IDX_W'(1);
	assign fold0   = qv0_q ? rd0_q : UNREACH;
	assign fold1   = qv1_q ? rd1_q : UNREACH;

	// Saturated sum of the range minimum and the interval cost.
	assign best_ok  = best_q != UNREACH;
	assign sum_full = {1'b0, best_q} + (COST_W+1)'(cost_q);
	assign sum_sat  = (sum_full > (COST_W+1)'(UNREACH)) ? UNREACH : sum_full[COST_W-1:0];

	// Update walks from the leaf to the root while the node index is nonzero.
	assign u_issue = cmd.update && (u_q != '0);

	// Target entry lookup.
	assign t1   = {1'b0, target_point} + (PT_W+1)'(1);
	assign t_ok = !t1[PT_W];
	assign ans  = tok_q ? rd0_q : UNREACH;

	// Reset image: the root-to-leaf path of the empty prefix entry is zero.
	assign clr_path = (clr_q == NODE_W'(INIT_NODE)) ||
		(!clr_q[NODE_W-1] && (clr_q != '0) && ((clr_q & (clr_q - NODE_W'(1))) == '0));
	assign clr_val  = clr_path ? '0 : UNREACH;

	// Memory port selection.
	always_comb begin
		rd_en0   = 1'b0;
		rd_addr0 = lo_q[NODE_W-1:0];
		rd_en1   = q_issue && hi_q[0];
		rd_addr1 = hi_m1[NODE_W-1:0];
		if (q_issue) begin
			rd_en0 = lo_q[0];
		end else if (u_issue) begin
			rd_en0   = 1'b1;
			rd_addr0 = u_q;
		end else if (cmd.tread) begin
			rd_en0   = t_ok;
			rd_addr0 = NODE_W'(LEAVES) + NODE_W'(t1);
		end
		wr_en   = cmd.clear || wpend_q;
		wr_addr = cmd.clear ? clr_q : waddr_q;
		wr_data = cmd.clear ? clr_val : cost_min(rd0_q, reach_cost_q);
	end

	// Tree memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tree_mem[wr_addr] <= wr_data;
		end
		if (rd_en0) begin
			rd0_q <= tree_mem[rd_addr0];
		end
		if (rd_en1) begin
			rd1_q <= tree_mem[rd_addr1];
		end
	end

	// Sequencing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			qv0_q   <= 1'b0;
			qv1_q   <= 1'b0;
			u_q     <= '0;
			wpend_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + NODE_W'(1);
			end
			qv0_q   <= q_issue && lo_q[0];
			qv1_q   <= q_issue && hi_q[0];
			wpend_q <= u_issue;
			if (cmd.load) begin
				lo_q <= lo_init;
				hi_q <= hi_init;
				u_q  <= e1[PT_W] ? '0 : (NODE_W'(LEAVES) + NODE_W'(e1));
			end else if (q_issue) begin
				lo_q <= (lo_q + IDX_W'(1)) >> 1;
				hi_q <= hi_q >> 1;
			end
			if (cmd.sum && !best_ok) begin
				u_q <= '0;
			end else if (u_issue) begin
				u_q <= u_q >> 1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cost_q <= interval_cost;
			last_q <= last_interval;
			best_q <= UNREACH;
		end else if (cmd.query) begin
			best_q <= cost_min(best_q, cost_min(fold0, fold1));
		end
		if (u_issue) begin
			waddr_q <= u_q;
		end
		if (cmd.sum) begin
			reach_valid_q <= best_ok;
			reach_cost_q  <= best_ok ? sum_sat : UNREACH;
		end
		if (cmd.tread) begin
			tok_q <= t_ok;
		end
		if (cmd.tcap) begin
			answer_found_q <= ans != UNREACH;
			answer_cost_q  <= (ans != UNREACH) ? ans : '0;
		end
	end

	assign sts.clear_last  = clr_q == '1;
	assign sts.query_done  = !(lo_q < hi_q);
	assign sts.update_done = u_q == '0;

	assign reach_cost   = reach_cost_q;
	assign reach_valid  = reach_valid_q;
	assign answer_cost  = answer_cost_q;
	assign answer_found = answer_found_q;
	assign answer_final = last_q;

endmodule
